// File: hw/rtl/tab_set_record_decoder_defines.svh
// Assertion macros shared by the tab-set record decoder modules.
`ifndef TAB_SET_RECORD_DECODER_DEFINES_SVH
`define TAB_SET_RECORD_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF

`define TSRD_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define TSRD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define TSRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define TSRD_ASSERT(lbl, cond, msg)
`define TSRD_ASSERT_SAME(lbl, ante, cons, msg)
`define TSRD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: hw/rtl/tsrd_pkg.sv
// Types, constants and helpers shared by the tab-set record decoder.
`timescale 1ns / 1ps
`default_nettype none

package tsrd_pkg;

  localparam int MAX_REPEAT_DEFAULT = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = 2;
  localparam int QUEUE_CW = 3;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_PLAIN  = 2'd1;
  localparam logic [1:0] CMD_REPEAT = 2'd2;

  localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] POS_MIN = -24'sh800000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_record;
  } in_t;

  typedef struct packed {
    logic signed [23:0] stop_position;
    logic [2:0]         alignment;
    logic [1:0]         leader_kind;
    logic               old_leader_method;
    logic               relative_tabs;
    logic               last_of_run;
    logic               repeat_clamped;
  } out_t;

  typedef struct packed {
    logic [2:0] alignment;
    logic [1:0] leader_kind;
    logic       old_method;
  } attr_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [16:0] value;
    logic [6:0]  count;
    logic        clamped;
    logic        relative;
    attr_t       attr;
  } cmd_t;

  function automatic attr_t decode_type(input logic [7:0] b);
    attr_t a;
    a.alignment = (b[3:0] <= 4'd4) ? b[2:0] : 3'd0;
    if (!b[4]) begin
      a.leader_kind = 2'd0;
      a.old_method  = 1'b0;
    end else begin
      a.leader_kind = (b[6:5] == 2'd0) ? 2'd1 : b[6:5];
      a.old_method  = (b[6:5] == 2'd0);
    end
    return a;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tsrd_front.sv
// Byte parser that walks the record layout and issues stop commands.
`timescale 1ns / 1ps
`default_nettype none

module tsrd_front #(
  parameter int MAX_REPEAT = tsrd_pkg::MAX_REPEAT_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire tsrd_pkg::in_t in_item,
  input  wire logic          q_full,
  output logic               push,
  output tsrd_pkg::cmd_t     push_cmd
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_ADJ_LO = 3'd1;
  localparam logic [2:0] PH_ADJ_HI = 3'd2;
  localparam logic [2:0] PH_COUNT  = 3'd3;
  localparam logic [2:0] PH_TYPE   = 3'd4;
  localparam logic [2:0] PH_POS_LO = 3'd5;
  localparam logic [2:0] PH_POS_HI = 3'd6;

  localparam logic [6:0] RepeatLimit = 7'(MAX_REPEAT);

  logic [2:0]      phase;
  logic            is_relative;
  logic [15:0]     adjust_value;
  logic [7:0]      stops_remaining;
  logic [7:0]      stops_left;
  logic [6:0]      repeat_count;
  tsrd_pkg::attr_t attr;
  logic [7:0]      low_byte_hold;
  logic            accept;
  logic [15:0]     pos_word;
  logic [15:0]     adj_eff;

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign pos_word   = {in_item.data_byte, low_byte_hold};
  assign adj_eff    = is_relative ? adjust_value : 16'd0;
  assign stops_left = stops_remaining - 8'd1;

  always_comb begin
    push              = 1'b0;
    push_cmd.kind     = tsrd_pkg::CMD_CLEAR;
    push_cmd.value    = {1'b0, pos_word};
    push_cmd.count    = repeat_count;
    push_cmd.clamped  = 1'b0;
    push_cmd.relative = is_relative;
    push_cmd.attr     = attr;
    if (accept) begin
      if (in_item.start_record) begin
        push = 1'b1;
      end else if (phase == PH_POS_HI) begin
        if (repeat_count == 7'd0) begin
          push           = (pos_word != 16'hFFFF);
          push_cmd.kind  = tsrd_pkg::CMD_PLAIN;
          push_cmd.value = {1'b0, pos_word} - {1'b0, adj_eff};
        end else begin
          push          = 1'b1;
          push_cmd.kind = tsrd_pkg::CMD_REPEAT;
          if (repeat_count > RepeatLimit) begin
            push_cmd.count   = RepeatLimit;
            push_cmd.clamped = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      is_relative     <= 1'b0;
      adjust_value    <= '0;
      stops_remaining <= '0;
      repeat_count    <= '0;
      attr            <= '0;
      low_byte_hold   <= '0;
    end else if (accept) begin
      if (in_item.start_record) begin
        is_relative     <= (in_item.data_byte != 8'd0);
        adjust_value    <= '0;
        stops_remaining <= '0;
        repeat_count    <= '0;
        attr            <= '0;
        phase           <= PH_ADJ_LO;
      end else begin
        case (phase)
          PH_ADJ_LO: begin
            low_byte_hold <= in_item.data_byte;
            phase         <= PH_ADJ_HI;
          end
          PH_ADJ_HI: begin
            adjust_value <= pos_word;
            phase        <= PH_COUNT;
          end
          PH_COUNT: begin
            stops_remaining <= in_item.data_byte;
            phase <= (in_item.data_byte == 8'd0) ? PH_IDLE : PH_TYPE;
          end
          PH_TYPE: begin
            if (in_item.data_byte[7]) begin
              repeat_count <= in_item.data_byte[6:0];
            end else begin
              attr <= tsrd_pkg::decode_type(in_item.data_byte);
            end
            phase <= PH_POS_LO;
          end
          PH_POS_LO: begin
            low_byte_hold <= in_item.data_byte;
            phase         <= PH_POS_HI;
          end
          PH_POS_HI: begin
            repeat_count    <= '0;
            stops_remaining <= stops_left;
            phase <= (stops_left == 8'd0) ? PH_IDLE : PH_TYPE;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tsrd_queue.sv
// Small command queue between the parser and the stop emitter.
`timescale 1ns / 1ps
`default_nettype none

`include "tab_set_record_decoder_defines.svh"

module tsrd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tsrd_pkg::cmd_t push_cmd,
  output logic                full,
  output logic                q_valid,
  output tsrd_pkg::cmd_t      q_cmd,
  input  wire logic           pop
);

  tsrd_pkg::cmd_t                 mem [tsrd_pkg::QUEUE_DEPTH];
  logic [tsrd_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [tsrd_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [tsrd_pkg::QUEUE_CW-1:0]  count;

  assign full    = (count == tsrd_pkg::QUEUE_CW'(tsrd_pkg::QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `TSRD_ASSERT(a_count_bound, count <= tsrd_pkg::QUEUE_CW'(tsrd_pkg::QUEUE_DEPTH), "queue overrun")

endmodule

`default_nettype wire

// File: hw/rtl/tsrd_back.sv
// Stop emitter that expands repeat runs and holds the output register.
`timescale 1ns / 1ps
`default_nettype none

`include "tab_set_record_decoder_defines.svh"

module tsrd_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire tsrd_pkg::cmd_t q_cmd,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output tsrd_pkg::out_t      out_item
);

  logic signed [23:0] last_pos;
  logic [6:0]         rem;
  logic [15:0]        step;
  tsrd_pkg::attr_t    run_attr;
  logic               run_rel;
  logic               run_clamped;
  logic               busy;
  logic               slot_free;
  logic               emit;
  tsrd_pkg::out_t     stop;
  logic [24:0]        sum;
  logic [23:0]        sat;

  assign busy      = (rem != 7'd0);
  assign slot_free = !out_valid || out_ready;
  assign sum       = {last_pos[23], last_pos} + {9'd0, step};
  assign sat       = (sum[24] != sum[23]) ? (sum[24] ? tsrd_pkg::POS_MIN : tsrd_pkg::POS_MAX)
                                          : sum[23:0];

  always_comb begin
    pop                    = 1'b0;
    emit                   = 1'b0;
    stop.stop_position     = sat;
    stop.alignment         = run_attr.alignment;
    stop.leader_kind       = run_attr.leader_kind;
    stop.old_leader_method = run_attr.old_method;
    stop.relative_tabs     = run_rel;
    stop.last_of_run       = (rem == 7'd1);
    stop.repeat_clamped    = run_clamped;
    if (slot_free) begin
      if (busy) begin
        emit = 1'b1;
      end else if (q_valid) begin
        pop = 1'b1;
        if (q_cmd.kind == tsrd_pkg::CMD_PLAIN) begin
          emit                   = 1'b1;
          stop.stop_position     = {{7{q_cmd.value[16]}}, q_cmd.value};
          stop.alignment         = q_cmd.attr.alignment;
          stop.leader_kind       = q_cmd.attr.leader_kind;
          stop.old_leader_method = q_cmd.attr.old_method;
          stop.relative_tabs     = q_cmd.relative;
          stop.last_of_run       = 1'b1;
          stop.repeat_clamped    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= stop;
    end
    if (pop && q_cmd.kind == tsrd_pkg::CMD_REPEAT) begin
      step        <= q_cmd.value[15:0];
      run_attr    <= q_cmd.attr;
      run_rel     <= q_cmd.relative;
      run_clamped <= q_cmd.clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rem       <= '0;
      last_pos  <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        last_pos  <= stop.stop_position;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (busy && emit) begin
        rem <= rem - 7'd1;
      end
      if (pop) begin
        case (q_cmd.kind)
          tsrd_pkg::CMD_CLEAR: begin
            last_pos <= '0;
          end
          tsrd_pkg::CMD_REPEAT: begin
            rem <= q_cmd.count;
          end
          default: begin
          end
        endcase
      end
    end
  end

  `TSRD_ASSERT_NEXT(a_clear_zeroes, pop && q_cmd.kind == tsrd_pkg::CMD_CLEAR, last_pos == '0, "clear did not zero position")
  `TSRD_ASSERT_NEXT(a_run_continues, emit && busy && !stop.last_of_run, rem != 7'd0, "repeat run ended early")
  `TSRD_ASSERT_SAME(a_no_pop_in_run, busy, !pop, "command taken during repeat run")

endmodule

`default_nettype wire

// File: hw/rtl/tab_set_record_decoder.sv
// Top level of the tab-set record decoder: parser, command queue and stop emitter.
// The block takes one record byte per cycle as long as its four-entry command
// queue has room. A plain entry is emitted as a single stop when it is taken;
// a repeat entry with count n (at most MAX_REPEAT) is loaded first and then
// emits n stops, each when the output slot is free, and the parser stalls only
// once the queue fills behind it. A byte with start_record set restarts
// parsing at once. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module tab_set_record_decoder #(
  parameter int MAX_REPEAT = tsrd_pkg::MAX_REPEAT_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire tsrd_pkg::in_t  in_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output tsrd_pkg::out_t      out_item
);

  logic           q_full;
  logic           push;
  tsrd_pkg::cmd_t push_cmd;
  logic           q_valid;
  tsrd_pkg::cmd_t q_cmd;
  logic           pop;

  tsrd_front #(
    .MAX_REPEAT(MAX_REPEAT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  tsrd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  tsrd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
